// ===== rtl/psc_pkg.sv =====
package psc_pkg;

   localparam int MAX_N_DEFAULT = 65536;
   localparam int LIMIT_W       = 17;
   localparam int COUNT_W       = 17;

endpackage

// ===== rtl/prime_sieve_counter_top.sv =====
// prime sieve counter: returns the number of primes in 2..limit
//
// input channel: req_limit is taken at a rising edge with start high and
// busy low; busy then stays high until the result is issued. limits above
// MAX_N are treated as MAX_N.
// result channel: rsp_prime_count is valid for exactly one cycle while
// rsp_valid is high. the receiver cannot stall, so it must take it then.
// one item is in work at a time.
//
// after reset the mark memory is swept clear, entries 0..MAX_N, with busy high.
// per item (n = saturated limit, r = floor(sqrt(n))): each base 2..r is read
// in S_BASE and checked in S_BASE_CHK, and a closing S_BASE step ends the base
// loop; each prime base writes its marks from b*b up to n in S_MARK, then a
// counting pass reads entries 2..n and also clears the entries it reads. every
// phase works through the single write port and single read port of the mark
// memory.
module prime_sieve_counter_top #(
   parameter int MAX_N = psc_pkg::MAX_N_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [psc_pkg::LIMIT_W-1:0]  req_limit,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic [psc_pkg::COUNT_W-1:0]  rsp_prime_count
);

   import psc_pkg::*;

   localparam int AW = $clog2(MAX_N + 1);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic          mem_rd_data;

   psc_ctrl #(
      .MAX_N (MAX_N),
      .AW    (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_limit       (req_limit),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_prime_count (rsp_prime_count),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   psc_mark_mem #(
      .DEPTH (MAX_N + 1),
      .AW    (AW)
   ) u_mark_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== rtl/psc_mark_mem.sv =====
module psc_mark_mem #(
   parameter int DEPTH = psc_pkg::MAX_N_DEFAULT + 1,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mark_mem [DEPTH];
   logic rd_data_ff;

   // read-first: a read and a write to the same entry return the old mark
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mark_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psc_ctrl.sv =====
module psc_ctrl #(
   parameter int MAX_N = psc_pkg::MAX_N_DEFAULT,
   parameter int AW    = $clog2(MAX_N + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [psc_pkg::LIMIT_W-1:0]  req_limit,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic [psc_pkg::COUNT_W-1:0]  rsp_prime_count,
   output logic                         mem_wr_en,
   output logic [AW-1:0]                mem_wr_addr,
   output logic                         mem_wr_data,
   output logic [AW-1:0]                mem_rd_addr,
   input  logic                         mem_rd_data
);

   import psc_pkg::*;

   localparam int CW = (AW + 1 > LIMIT_W) ? AW + 1 : LIMIT_W;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_BASE,
      S_BASE_CHK,
      S_MARK,
      S_COUNT
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        n_ff, n_in;
   logic [AW-1:0]        b_ff, b_in;
   logic [AW:0]          sq_ff, sq_in;
   logic [AW:0]          m_ff, m_in;
   logic [AW:0]          addr_ff, addr_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [AW:0]          n_ext;
   logic [AW:0]          sq_next;

   assign n_ext   = {1'b0, n_ff};
   // (b+1)^2 = b^2 + 2b + 1
   assign sq_next = sq_ff + {b_ff, 1'b1};

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      b_in         = b_ff;
      sq_in        = sq_ff;
      m_in         = m_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = 1'b0;
      mem_rd_addr  = '0;
      case (state_ff)
         S_INIT: begin
            // one full sweep after reset; each request leaves the store clear again
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_ff[AW-1:0];
            if (addr_ff == (AW+1)'(MAX_N)) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (CW'(req_limit) > CW'(MAX_N)) begin
                  n_in = AW'(MAX_N);
               end else begin
                  n_in = AW'(req_limit);
               end
               b_in     = AW'(2);
               sq_in    = (AW+1)'(4);
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            if (sq_ff <= n_ext) begin
               mem_rd_addr = b_ff;
               state_in    = S_BASE_CHK;
            end else begin
               addr_in  = (AW+1)'(2);
               cnt_in   = '0;
               pend_in  = 1'b0;
               state_in = S_COUNT;
            end
         end
         S_BASE_CHK: begin
            if (!mem_rd_data) begin
               m_in     = sq_ff;
               state_in = S_MARK;
            end else begin
               b_in     = b_ff + 1'b1;
               sq_in    = sq_next;
               state_in = S_BASE;
            end
         end
         S_MARK: begin
            if (m_ff <= n_ext) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = m_ff[AW-1:0];
               mem_wr_data = 1'b1;
               m_in        = m_ff + {1'b0, b_ff};
            end else begin
               b_in     = b_ff + 1'b1;
               sq_in    = sq_next;
               state_in = S_BASE;
            end
         end
         S_COUNT: begin
            // read each entry and clear it behind the read
            if (pend_ff && !mem_rd_data) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (addr_ff <= n_ext) begin
               mem_rd_addr = addr_ff[AW-1:0];
               mem_wr_en   = 1'b1;
               mem_wr_addr = addr_ff[AW-1:0];
               addr_in     = addr_ff + 1'b1;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = cnt_ff;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_INIT;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      b_ff         <= b_in;
      sq_ff        <= sq_in;
      m_ff         <= m_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK && mem_wr_en) |-> (mem_wr_data && m_ff <= n_ext))
      else $error("mark write outside 0..n");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_result_from_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_COUNT && state_ff == S_IDLE))
      else $error("result not issued at end of counting pass");

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BASE_CHK) |-> ($past(state_ff) == S_BASE))
      else $error("base check without a preceding read");
`endif

endmodule
